// File: rtl/core/gchv_pkg.sv
package gchv_pkg;

  localparam int CountW    = 32;
  localparam int CoordW    = 32;
  localparam int CfgAddrW  = 3;
  localparam int SInDataW  = 64;
  localparam int MOutDataW = 168;

  localparam logic [47:0] LcgMul    = 48'h0005DEECE66D;
  localparam logic [47:0] LcgAdd    = 48'h00000000000B;
  localparam logic [15:0] LcgSeedLo = 16'h330E;
  localparam logic [24:0] ProbeLimit = 25'd16777216;

  typedef enum logic [1:0] {
    REQ_STORE = 2'd0,
    REQ_CHECK = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_SPARE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_OVF   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CFG_X_MIN      = 3'd0,
    CFG_X_MAX      = 3'd1,
    CFG_X_SCALE    = 3'd2,
    CFG_Y_MIN      = 3'd3,
    CFG_Y_MAX      = 3'd4,
    CFG_Y_SCALE    = 3'd5,
    CFG_COORD_BASE = 3'd6,
    CFG_TABLE_SIZE = 3'd7
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_QX, S_QY, S_CELL, S_SUM, S_HOME, S_HWAIT,
    S_RD, S_CHK, S_FSCAN_RD, S_FSCAN_CHK, S_LCG1, S_LCG2, S_LCG3, S_LCG4,
    S_CDIV, S_CWAIT, S_CSCAN_RD, S_CSCAN_CHK, S_DONE
  } state_t;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    sat_inc = (v == {CountW{1'b1}}) ? v : v + CountW'(1);
  endfunction

endpackage

// File: rtl/core/gchv_div.sv
module gchv_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quot,
  output logic [31:0] rem
);

  logic [5:0]  cnt;
  logic        active;
  logic [32:0] rem_sh;
  logic [32:0] trial;

  assign rem_sh = {rem, quot[31]};
  assign trial  = rem_sh - {1'b0, divisor};

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= 6'd32;
      end else if (active) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
    end else if (active) begin
      if (!trial[32]) begin
        rem  <= trial[31:0];
        quot <= {quot[30:0], 1'b1};
      end else begin
        rem  <= rem_sh[31:0];
        quot <= {quot[30:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/core/grid_cell_hash_visit_table.sv
// Grid cell visit table. Counts how often 2-D Q16.16 points land in grid cells,
// keeping cells in an open-addressed hash table with drand48-style probing.
// Input channel s_*: s_tuser = request kind (store / cycle check / clear),
// s_tdata = x then y coordinate. Output channel m_*: one item per request,
// m_tuser = status, m_tdata = slot result and counter snapshot.
// cfg_*: register writes, taken every cycle; the user must write only while
// the block is idle, which the block itself does not enforce. A store runs
// the serial divider forming cell mod size, then reads and checks each
// probed slot, with an LCG step per probe collision; a full table adds a
// free-slot scan. A cycle check divides the hit total by the used slots and
// scans the slots in range. A clear sweeps the whole memory, one slot per
// cycle. Out-of-range points skip the table. One item is in work at a time.
// After reset the same sweep clears the memory; s_tready stays low until
// it ends. A stalled m_tready holds the result in the output
// register; the next item is still accepted and waits for the register.
module grid_cell_hash_visit_table #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [gchv_pkg::SInDataW-1:0]       s_tdata,  // x_coord, y_coord
  input  logic [1:0]                          s_tuser,  // req_type
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // is_new, slot, cell_id, slot_hits, total_hits, used_slots,
  // collision_total, cycle_order, zero pad
  output logic [gchv_pkg::MOutDataW-1:0]      m_tdata,
  output logic [1:0]                          m_tuser,  // status
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gchv_pkg::CfgAddrW-1:0]       cfg_addr,
  input  logic [31:0]                         cfg_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = gchv_pkg::CountW;
  localparam int MW = 32 + CW;

  // configuration
  logic signed [31:0] x_min, x_max, y_min, y_max;
  logic [31:0] x_scale, y_scale;
  logic [16:0] coord_base;
  logic [10:0] table_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min <= '0; x_max <= 32'sd65536; x_scale <= 32'd65536;
      y_min <= '0; y_max <= 32'sd65536; y_scale <= 32'd65536;
      coord_base <= 17'd256;
      table_size <= 11'd1024;
    end else if (cfg_valid && cfg_ready) begin
      case (gchv_pkg::cfg_idx_t'(cfg_addr))
        gchv_pkg::CFG_X_MIN:      x_min <= cfg_data;
        gchv_pkg::CFG_X_MAX:      x_max <= cfg_data;
        gchv_pkg::CFG_X_SCALE:    x_scale <= cfg_data;
        gchv_pkg::CFG_Y_MIN:      y_min <= cfg_data;
        gchv_pkg::CFG_Y_MAX:      y_max <= cfg_data;
        gchv_pkg::CFG_Y_SCALE:    y_scale <= cfg_data;
        gchv_pkg::CFG_COORD_BASE: coord_base <= cfg_data[16:0];
        gchv_pkg::CFG_TABLE_SIZE: table_size <= cfg_data[10:0];
        default: ;
      endcase
    end
  end
  assign cfg_ready = 1'b1;

  logic [SW-1:0] eff;
  always_comb begin
    if (table_size == 11'd0) eff = SW'(1);
    else if (32'(table_size) > 32'(TABLE_DEPTH)) eff = SW'(TABLE_DEPTH);
    else eff = SW'(table_size);
  end

  // table memory: {cell id, hit count}
  logic [MW-1:0] mem [TABLE_DEPTH];
  logic [MW-1:0] mem_rdata, mem_wdata;
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic          mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  logic [CW-1:0] rd_cnt;
  logic [31:0]   rd_cell;
  assign rd_cnt  = mem_rdata[CW-1:0];
  assign rd_cell = mem_rdata[MW-1:CW];

  // working registers
  gchv_pkg::state_t state, state_next;
  logic        div_start, div_done;
  logic [1:0]  req;
  logic signed [31:0] xc, yc;
  logic [31:0] ix, iy, cprod, cell_num;
  logic [AW-1:0] home, b;
  logic [47:0] lcg;
  logic [58:0] p_lo;
  logic [23:0] p_hi;
  logic [24:0] probes;
  logic        free_known, free_ok;
  logic [SW-1:0] idx;
  logic [31:0] q, r;
  logic        clr_reply;
  logic [CW-1:0] hit_total, coll_count;
  logic [SW-1:0] used_count;

  logic [1:0]    res_status;
  logic          res_is_new;
  logic [AW-1:0] res_slot;
  logic [31:0]   res_cell;
  logic [CW-1:0] res_hits;
  logic [SW-1:0] res_order;

  logic [31:0] div_dividend, div_divisor, div_quot, div_rem;

  gchv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // operands stay put for the whole division
  assign div_dividend = (req == gchv_pkg::REQ_STORE) ? cell_num : 32'(hit_total);
  assign div_divisor  = (req == gchv_pkg::REQ_STORE) ? 32'(eff) : 32'(used_count);

  // combinational datapath pieces
  logic [31:0] dx, dy;
  logic [63:0] qx_prod, qy_prod;
  logic [48:0] c_prod;
  logic [47+SW:0] b_prod;
  logic out_range, last_idx, is_last_clr;
  logic [32:0] h33, q33, hm1, hm2;
  logic cbad;

  assign dx        = xc - x_min;
  assign dy        = yc - y_min;
  assign qx_prod   = {32'b0, dx} * {32'b0, x_scale};
  assign qy_prod   = {32'b0, dy} * {32'b0, y_scale};
  assign c_prod    = {17'b0, iy} * {32'b0, coord_base};
  assign b_prod    = {SW'(0), lcg} * {48'b0, eff};
  assign out_range = (xc < x_min) || (xc > x_max) || (yc < y_min) || (yc > y_max);
  assign last_idx  = (idx == eff - SW'(1));
  assign is_last_clr = (idx == SW'(TABLE_DEPTH - 1));

  assign h33 = {1'b0, 32'(rd_cnt)};
  assign q33 = {1'b0, q};
  assign hm1 = h33 - 33'd1;
  assign hm2 = h33 - 33'd2;
  // slot breaks the periodic pattern: too few hits or far from the mean
  assign cbad = (rd_cnt != '0) &&
                ((rd_cnt < CW'(2)) ||
                 !((q33 >= hm1) || ((q33 == hm2) && (r != 32'd0))) ||
                 ((q != 32'd0) && (q33 - 33'd1 > h33)));

  logic collide, hit_empty, hit_match;
  assign hit_empty = (rd_cnt == '0);
  assign hit_match = !hit_empty && (rd_cell == cell_num);
  assign collide   = !hit_empty && !hit_match;

  logic done_ready;
  assign done_ready = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gchv_pkg::S_CLEAR:  if (is_last_clr) state_next = clr_reply ? gchv_pkg::S_DONE
                                                                   : gchv_pkg::S_IDLE;
      gchv_pkg::S_IDLE: begin
        if (s_tvalid) begin
          case (gchv_pkg::req_t'(s_tuser))
            gchv_pkg::REQ_STORE: state_next = gchv_pkg::S_QX;
            gchv_pkg::REQ_CHECK: state_next = (used_count != '0) ? gchv_pkg::S_CDIV
                                                                  : gchv_pkg::S_DONE;
            gchv_pkg::REQ_CLEAR: state_next = gchv_pkg::S_CLEAR;
            default:             state_next = gchv_pkg::S_DONE;
          endcase
        end
      end
      gchv_pkg::S_QX:     state_next = out_range ? gchv_pkg::S_DONE : gchv_pkg::S_QY;
      gchv_pkg::S_QY:     state_next = gchv_pkg::S_CELL;
      gchv_pkg::S_CELL:   state_next = gchv_pkg::S_SUM;
      gchv_pkg::S_SUM:    state_next = gchv_pkg::S_HOME;
      gchv_pkg::S_HOME:   state_next = gchv_pkg::S_HWAIT;
      gchv_pkg::S_HWAIT:  if (div_done) state_next = gchv_pkg::S_RD;
      gchv_pkg::S_RD:     state_next = gchv_pkg::S_CHK;
      gchv_pkg::S_CHK: begin
        if (!collide) state_next = gchv_pkg::S_DONE;
        else if (probes >= gchv_pkg::ProbeLimit) state_next = gchv_pkg::S_DONE;
        else if (free_known) state_next = free_ok ? gchv_pkg::S_LCG1 : gchv_pkg::S_DONE;
        else if (SW'(used_count) < eff) state_next = gchv_pkg::S_LCG1;
        else state_next = gchv_pkg::S_FSCAN_RD;
      end
      gchv_pkg::S_FSCAN_RD:  state_next = gchv_pkg::S_FSCAN_CHK;
      gchv_pkg::S_FSCAN_CHK: begin
        if (rd_cnt == '0) state_next = gchv_pkg::S_LCG1;
        else if (last_idx) state_next = gchv_pkg::S_DONE;
        else state_next = gchv_pkg::S_FSCAN_RD;
      end
      gchv_pkg::S_LCG1:   state_next = gchv_pkg::S_LCG2;
      gchv_pkg::S_LCG2:   state_next = gchv_pkg::S_LCG3;
      gchv_pkg::S_LCG3:   state_next = gchv_pkg::S_LCG4;
      gchv_pkg::S_LCG4:   state_next = gchv_pkg::S_RD;
      gchv_pkg::S_CDIV:   state_next = gchv_pkg::S_CWAIT;
      gchv_pkg::S_CWAIT:  if (div_done) state_next = gchv_pkg::S_CSCAN_RD;
      gchv_pkg::S_CSCAN_RD:  state_next = gchv_pkg::S_CSCAN_CHK;
      gchv_pkg::S_CSCAN_CHK: begin
        if (cbad || last_idx) state_next = gchv_pkg::S_DONE;
        else state_next = gchv_pkg::S_CSCAN_RD;
      end
      gchv_pkg::S_DONE:   if (done_ready) state_next = gchv_pkg::S_IDLE;
      default:            state_next = gchv_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = b;
    mem_wdata     = {cell_num, gchv_pkg::sat_inc(rd_cnt)};
    mem_raddr     = b;
    div_start     = 1'b0;
    case (state)
      gchv_pkg::S_IDLE:  s_tready = 1'b1;
      gchv_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx[AW-1:0];
        mem_wdata = '0;
      end
      gchv_pkg::S_CHK:   mem_we = !collide;
      gchv_pkg::S_FSCAN_RD, gchv_pkg::S_CSCAN_RD: mem_raddr = idx[AW-1:0];
      gchv_pkg::S_HOME, gchv_pkg::S_CDIV: div_start = 1'b1;
      default: ;
    endcase
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gchv_pkg::S_CLEAR;
      idx        <= '0;
      clr_reply  <= 1'b0;
      hit_total  <= '0;
      used_count <= '0;
      coll_count <= '0;
      lcg        <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == gchv_pkg::S_DONE && done_ready) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        gchv_pkg::S_CLEAR: begin
          idx <= idx + SW'(1);
          if (is_last_clr) begin
            hit_total  <= '0;
            used_count <= '0;
            coll_count <= '0;
          end
        end
        gchv_pkg::S_IDLE: begin
          idx <= '0;
          if (s_tvalid) clr_reply <= (s_tuser == gchv_pkg::REQ_CLEAR);
        end
        gchv_pkg::S_HWAIT: if (div_done) lcg <= {32'(div_rem), gchv_pkg::LcgSeedLo};
        gchv_pkg::S_CHK: begin
          if (hit_empty) used_count <= used_count + SW'(1);
          if (!collide) hit_total <= gchv_pkg::sat_inc(hit_total);
        end
        gchv_pkg::S_FSCAN_CHK, gchv_pkg::S_CSCAN_CHK: idx <= idx + SW'(1);
        gchv_pkg::S_LCG3: lcg <= p_lo[47:0] + {p_hi, 24'b0} + gchv_pkg::LcgAdd;
        gchv_pkg::S_LCG4: coll_count <= gchv_pkg::sat_inc(coll_count);
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (state)
      gchv_pkg::S_IDLE: begin
        req        <= s_tuser;
        xc         <= s_tdata[31:0];
        yc         <= s_tdata[63:32];
        probes     <= '0;
        free_known <= 1'b0;
        free_ok    <= 1'b0;
        res_status <= gchv_pkg::STAT_OK;
        res_is_new <= 1'b0;
        res_slot   <= '0;
        res_cell   <= '0;
        res_hits   <= '0;
        res_order  <= '0;
      end
      gchv_pkg::S_QX: begin
        ix <= qx_prod[63:32];
        if (out_range) res_status <= gchv_pkg::STAT_RANGE;
      end
      gchv_pkg::S_QY:   iy <= qy_prod[63:32];
      gchv_pkg::S_CELL: cprod <= c_prod[31:0];
      gchv_pkg::S_SUM:  cell_num <= ix + cprod;
      gchv_pkg::S_HWAIT: begin
        home <= AW'(div_rem);
        b    <= AW'(div_rem);
      end
      gchv_pkg::S_CHK: begin
        res_cell <= cell_num;
        if (!collide) begin
          res_is_new <= hit_empty;
          res_slot   <= b;
          res_hits   <= gchv_pkg::sat_inc(rd_cnt);
        end else if (probes >= gchv_pkg::ProbeLimit || (free_known && !free_ok)) begin
          res_status <= gchv_pkg::STAT_OVF;
          res_slot   <= home;
        end else if (!free_known && SW'(used_count) < eff) begin
          free_known <= 1'b1;
          free_ok    <= 1'b1;
        end
      end
      gchv_pkg::S_FSCAN_CHK: begin
        if (rd_cnt == '0) begin
          free_known <= 1'b1;
          free_ok    <= 1'b1;
        end else if (last_idx) begin
          free_known <= 1'b1;
          res_status <= gchv_pkg::STAT_OVF;
          res_slot   <= home;
        end
      end
      gchv_pkg::S_LCG1: begin
        p_lo   <= {35'b0, lcg[23:0]} * {24'b0, gchv_pkg::LcgMul[34:0]};
        probes <= probes + 25'd1;
      end
      gchv_pkg::S_LCG2: p_hi <= lcg[47:24] * gchv_pkg::LcgMul[23:0];
      gchv_pkg::S_LCG4: b <= AW'(b_prod[47+SW:48]);
      gchv_pkg::S_CWAIT: begin
        q <= div_quot;
        r <= div_rem;
      end
      gchv_pkg::S_CSCAN_CHK: begin
        if (!cbad && last_idx) res_order <= used_count;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == gchv_pkg::S_DONE && done_ready) begin
      m_tuser <= res_status;
      m_tdata <= {7'b0, 11'(res_order), 32'(coll_count), 11'(used_count),
                  32'(hit_total), 32'(res_hits), res_cell, 10'(res_slot), res_is_new};
    end
  end

endmodule

// File: rtl/core/gchv_chk.sv
module gchv_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [gchv_pkg::MOutDataW-1:0] m_tdata,
  input logic [1:0]                     m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result item dropped while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid && !s_tready)
    else $error("block active right after reset");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == gchv_pkg::STAT_RANGE |-> m_tdata[74:0] == '0)
    else $error("rejected point reports slot data");

  a_new: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tuser == gchv_pkg::STAT_OK && m_tdata[74:43] == 32'd1
      && m_tdata[117:107] != 11'd0)
    else $error("new slot without a single hit");

  a_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[160:150] != 11'd0 |-> m_tdata[160:150] == m_tdata[117:107])
    else $error("period differs from used slot count");

endmodule

bind grid_cell_hash_visit_table gchv_chk u_gchv_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: dv/grid_cell_hash_visit_table_test.sv
`timescale 1ns / 1ps

module grid_cell_hash_visit_table_test;

  localparam int Depth = 1024;
  localparam longint CycleLimit = 20000000;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_new;
    logic [9:0]  slot;
    logic [31:0] cell_id;
    logic [31:0] slot_hits;
    logic [31:0] total_hits;
    logic [10:0] used_slots;
    logic [31:0] collision_total;
    logic [10:0] cycle_order;
  } visit_result_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [gchv_pkg::SInDataW-1:0] s_tdata;
  logic [1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [gchv_pkg::MOutDataW-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic [gchv_pkg::CfgAddrW-1:0] cfg_addr;
  logic [31:0] cfg_data;

  grid_cell_hash_visit_table #(.TABLE_DEPTH(Depth)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow of the block: registers and table
  logic signed [31:0] xmin_r, xmax_r, ymin_r, ymax_r;
  logic [31:0] xscale_r, yscale_r;
  logic [16:0] base_r;
  logic [10:0] size_r;
  logic [31:0] cell_mem [Depth];
  logic [31:0] count_mem [Depth];
  logic [31:0] hits_sum;
  logic [10:0] used_cnt;
  logic [31:0] coll_cnt;
  logic [47:0] lcg_x;

  visit_result_t pending_results[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycle_cnt = 0;

  function automatic logic [31:0] sat32(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic int eff_size();
    if (size_r == 0) return 1;
    if (size_r > Depth) return Depth;
    return size_r;
  endfunction

  function automatic logic [31:0] axis_index(input logic signed [31:0] c,
                                             input logic signed [31:0] lo,
                                             input logic [31:0] scale);
    logic [31:0] diff;
    logic [63:0] prod;
    diff = c - lo;
    prod = {32'd0, diff} * {32'd0, scale};
    return prod[63:32];
  endfunction

  task automatic clear_shadow();
    for (int i = 0; i < Depth; i++) begin
      cell_mem[i] = '0;
      count_mem[i] = '0;
    end
    hits_sum = '0;
    used_cnt = '0;
    coll_cnt = '0;
  endtask

  function automatic logic [10:0] periodic_order();
    int sz;
    longint unsigned q, r, h;
    sz = eff_size();
    if (used_cnt == 0) return '0;
    q = hits_sum / used_cnt;
    r = hits_sum % used_cnt;
    for (int i = 0; i < sz; i++) begin
      h = count_mem[i];
      if (h != 0) begin
        if (h < 2) return '0;
        if (!(q >= h - 1 || (q == h - 2 && r > 0))) return '0;
        if (q != 0 && q - 1 > h) return '0;
      end
    end
    return used_cnt;
  endfunction

  task automatic visit_table_update(input logic [1:0] req, input logic signed [31:0] xc,
                                    input logic signed [31:0] yc,
                                    output visit_result_t res);
    int sz, home, b, probes;
    logic [31:0] ix, iy, cell_num;
    logic [63:0] cell_w;
    logic [95:0] prod;
    logic [63:0] pick;
    bit done, any_free;
    res = '0;
    if (req == gchv_pkg::REQ_STORE) begin
      if (xc < xmin_r || xc > xmax_r || yc < ymin_r || yc > ymax_r) begin
        res.status = gchv_pkg::STAT_RANGE;
      end else begin
        sz = eff_size();
        ix = axis_index(xc, xmin_r, xscale_r);
        iy = axis_index(yc, ymin_r, yscale_r);
        cell_w = {32'd0, ix} + {32'd0, iy} * {47'd0, base_r};
        cell_num = cell_w[31:0];
        home = cell_num % sz;
        b = home;
        lcg_x = {home[31:0], gchv_pkg::LcgSeedLo};
        probes = 0;
        done = 0;
        while (!done) begin
          if (count_mem[b] == 0) begin
            cell_mem[b] = cell_num;
            used_cnt++;
            res.is_new = 1'b1;
            done = 1;
          end else if (cell_mem[b] == cell_num) begin
            done = 1;
          end else begin
            any_free = 0;
            for (int i = 0; i < sz; i++) if (count_mem[i] == 0) any_free = 1;
            if (!any_free || probes >= 16777216) begin
              res.status = gchv_pkg::STAT_OVF;
              done = 1;
            end else begin
              probes++;
              prod = {48'd0, lcg_x} * {48'd0, gchv_pkg::LcgMul};
              lcg_x = prod[47:0] + gchv_pkg::LcgAdd;
              pick = ({16'd0, lcg_x} * sz) >> 48;
              b = int'(pick);
              coll_cnt = sat32(coll_cnt);
            end
          end
        end
        res.cell_id = cell_num;
        if (res.status == gchv_pkg::STAT_OVF) begin
          res.slot = home[9:0];
        end else begin
          count_mem[b] = sat32(count_mem[b]);
          hits_sum = sat32(hits_sum);
          res.slot = b[9:0];
          res.slot_hits = count_mem[b];
        end
      end
    end else if (req == gchv_pkg::REQ_CHECK) begin
      res.cycle_order = periodic_order();
    end else if (req == gchv_pkg::REQ_CLEAR) begin
      clear_shadow();
    end
    res.total_hits = hits_sum;
    res.used_slots = used_cnt;
    res.collision_total = coll_cnt;
  endtask

  task automatic send_item(input logic [1:0] req, input logic [31:0] xc,
                           input logic [31:0] yc);
    visit_result_t res;
    cfg_valid <= 1'b0;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {yc, xc};
    do @(posedge clk); while (!s_tready);
    visit_table_update(req, xc, yc, res);
    pending_results.push_back(res);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // valid is dropped by the next send_item
  task automatic write_reg(input gchv_pkg::cfg_idx_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      gchv_pkg::CFG_X_MIN:      xmin_r = val;
      gchv_pkg::CFG_X_MAX:      xmax_r = val;
      gchv_pkg::CFG_X_SCALE:    xscale_r = val;
      gchv_pkg::CFG_Y_MIN:      ymin_r = val;
      gchv_pkg::CFG_Y_MAX:      ymax_r = val;
      gchv_pkg::CFG_Y_SCALE:    yscale_r = val;
      gchv_pkg::CFG_COORD_BASE: base_r = val[16:0];
      gchv_pkg::CFG_TABLE_SIZE: size_r = val[10:0];
      default: ;
    endcase
  endtask

  // grid of res x res cells over [lo, hi] on both axes
  task automatic set_grid(input int lo, input int hi, input int res, input int tsize);
    longint unsigned w, sc;
    drain();
    w = longint'(hi) - longint'(lo);
    sc = (w == 0) ? 32'hFFFF_FFFF : ((longint'(res - 1) << 32) / w);
    if (sc > 32'hFFFF_FFFF) sc = 32'hFFFF_FFFF;
    write_reg(gchv_pkg::CFG_X_MIN, lo);
    write_reg(gchv_pkg::CFG_X_MAX, hi);
    write_reg(gchv_pkg::CFG_X_SCALE, sc[31:0]);
    write_reg(gchv_pkg::CFG_Y_MIN, lo);
    write_reg(gchv_pkg::CFG_Y_MAX, hi);
    write_reg(gchv_pkg::CFG_Y_SCALE, sc[31:0]);
    write_reg(gchv_pkg::CFG_COORD_BASE, res + 1);
    write_reg(gchv_pkg::CFG_TABLE_SIZE, tsize);
  endtask

  function automatic logic [31:0] in_domain(input logic signed [31:0] lo,
                                            input logic signed [31:0] hi);
    longint unsigned span;
    span = longint'(hi) - longint'(lo);
    return lo + 32'({$urandom, $urandom} % (span + 1));
  endfunction

  task automatic test_reset_values();
    send_item(gchv_pkg::REQ_CHECK, 0, 0);
    send_item(gchv_pkg::REQ_STORE, 0, 0);
    send_item(gchv_pkg::REQ_STORE, 32'd65536, 32'd65536);
    send_item(gchv_pkg::REQ_STORE, 32'd32768, 32'd65535);
    send_item(gchv_pkg::REQ_STORE, 32'hFFFF_FFFF, 0);
    send_item(gchv_pkg::REQ_STORE, 0, 32'd65537);
    send_item(gchv_pkg::REQ_STORE, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(gchv_pkg::REQ_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(gchv_pkg::REQ_CHECK, 0, 0);
    send_item(gchv_pkg::REQ_CLEAR, 0, 0);
    send_item(gchv_pkg::REQ_CHECK, 0, 0);
    drain();
  endtask

  task automatic test_extreme_config();
    write_reg(gchv_pkg::CFG_X_MIN, 32'h8000_0000);
    write_reg(gchv_pkg::CFG_X_MAX, 32'h7FFF_FFFF);
    write_reg(gchv_pkg::CFG_X_SCALE, 32'hFFFF_FFFF);
    write_reg(gchv_pkg::CFG_Y_MIN, 32'h8000_0000);
    write_reg(gchv_pkg::CFG_Y_MAX, 32'h7FFF_FFFF);
    write_reg(gchv_pkg::CFG_Y_SCALE, 32'hFFFF_FFFF);
    write_reg(gchv_pkg::CFG_COORD_BASE, 32'd65536);
    write_reg(gchv_pkg::CFG_TABLE_SIZE, 32'd2047);
    send_item(gchv_pkg::REQ_STORE, 32'h8000_0000, 32'h8000_0000);
    send_item(gchv_pkg::REQ_STORE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(gchv_pkg::REQ_STORE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain();
    write_reg(gchv_pkg::CFG_COORD_BASE, 32'd1);
    write_reg(gchv_pkg::CFG_X_SCALE, 32'd0);
    write_reg(gchv_pkg::CFG_TABLE_SIZE, 32'd0);  // acts as one slot
    send_item(gchv_pkg::REQ_STORE, 32'd5, 32'd7);
    send_item(gchv_pkg::REQ_STORE, 32'd5, 32'd7);
    send_item(gchv_pkg::REQ_STORE, 32'h4000_0000, 32'h4000_0000);
    drain();
    // empty domain
    write_reg(gchv_pkg::CFG_X_MIN, 32'd100);
    write_reg(gchv_pkg::CFG_X_MAX, 32'd99);
    send_item(gchv_pkg::REQ_STORE, 32'd99, 0);
    send_item(gchv_pkg::REQ_STORE, 32'd100, 0);
    send_item(gchv_pkg::REQ_CLEAR, 0, 0);
    drain();
  endtask

  task automatic test_overflow();
    set_grid(0, 32'h0010_0000, 16, 4);
    for (int i = 0; i < 7; i++) send_item(gchv_pkg::REQ_STORE, i << 16, (i * 3) << 16);
    send_item(gchv_pkg::REQ_STORE, 0, 0);
    set_grid(0, 32'h0010_0000, 16, 1);
    send_item(gchv_pkg::REQ_STORE, 32'h0005_0000, 32'h0005_0000);
    send_item(gchv_pkg::REQ_CLEAR, 0, 0);
    drain();
  endtask

  // repeat a short orbit so the table looks periodic, then check it
  task automatic run_orbit(input int period, input int laps, input bit spoil);
    logic [31:0] px [8];
    for (int i = 0; i < period; i++) px[i] = in_domain(xmin_r, xmax_r);
    send_item(gchv_pkg::REQ_CLEAR, 0, 0);
    for (int l = 0; l < laps; l++)
      for (int i = 0; i < period; i++) send_item(gchv_pkg::REQ_STORE, px[i], px[i]);
    if (spoil) send_item(gchv_pkg::REQ_STORE, px[0], px[0]);
    send_item(gchv_pkg::REQ_CHECK, 0, 0);
  endtask

  task automatic test_cycle_check();
    set_grid(32'hFFF0_0000, 32'h0010_0000, 32, 64);
    run_orbit(3, 3, 0);
    run_orbit(4, 1, 0);
    run_orbit(5, 2, 1);
    drain();
  endtask

  task automatic test_random(input int n_items);
    int pick, lo, hi;
    lo = -$urandom_range(64) << 16;
    hi = $urandom_range(64, 1) << 16;
    case ($urandom_range(3))
      0: set_grid(lo, hi, $urandom_range(12, 2), $urandom_range(24, 4));
      1: set_grid(lo, hi, $urandom_range(40, 8), $urandom_range(200, 32));
      2: set_grid(lo, hi, $urandom_range(64, 16), 1024);
      default: set_grid(lo, hi, $urandom_range(30, 4), $urandom_range(1023, 1));
    endcase
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(99);
      if (pick < 68) begin
        send_item(gchv_pkg::REQ_STORE, in_domain(xmin_r, xmax_r), in_domain(ymin_r, ymax_r));
      end else if (pick < 76) begin
        send_item($urandom_range(3), $urandom, $urandom);
      end else if (pick < 82) begin
        send_item(gchv_pkg::REQ_STORE, xmax_r + $urandom_range(1000, 1),
                  in_domain(ymin_r, ymax_r));
      end else if (pick < 88) begin
        send_item(gchv_pkg::REQ_CHECK, $urandom, $urandom);
      end else if (pick < 89) begin
        send_item(gchv_pkg::REQ_CLEAR, $urandom, $urandom);
      end else begin
        // an orbit sends about 14 items
        run_orbit($urandom_range(8, 1), $urandom_range(4, 1), $urandom_range(1));
        k += 13;
      end
    end
    drain();
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    visit_result_t want;
    visit_result_t got;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      if (!rst && m_tvalid && m_tready) begin
        got.status          = m_tuser;
        got.is_new          = m_tdata[0];
        got.slot            = m_tdata[10:1];
        got.cell_id         = m_tdata[42:11];
        got.slot_hits       = m_tdata[74:43];
        got.total_hits      = m_tdata[106:75];
        got.used_slots      = m_tdata[117:107];
        got.collision_total = m_tdata[149:118];
        got.cycle_order     = m_tdata[160:150];
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item: %p", got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch\n  exp %p\n  got %p", want, got);
          end
        end
      end
      m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= gchv_pkg::REQ_STORE;
    cfg_valid <= 1'b0;
    cfg_addr <= gchv_pkg::CFG_X_MIN;
    cfg_data <= '0;
    xmin_r = 0; xmax_r = 65536; xscale_r = 65536;
    ymin_r = 0; ymax_r = 65536; yscale_r = 65536;
    base_r = 256; size_r = 1024;
    lcg_x = '0;
    clear_shadow();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_extreme_config();
    test_overflow();
    test_cycle_check();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(460);
    send_idle_pct = 65; recv_stall_pct = 0;  test_random(460);
    send_idle_pct = 0;  recv_stall_pct = 65; test_random(460);
    send_idle_pct = 11; recv_stall_pct = 11; test_random(460);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
